// ----- rtl/vntc_pkg.sv -----
// Package with types, constants and arithmetic helpers for the terrain classifier.
package vntc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int LERP_W = 31 + FRAC_BITS + 1;

    localparam logic [2:0] REG_SEED  = 3'd0;
    localparam logic [2:0] REG_SCALE = 3'd1;
    localparam logic [2:0] REG_WATER = 3'd2;
    localparam logic [2:0] REG_GRASS = 3'd3;
    localparam logic [2:0] REG_TREE  = 3'd4;

    localparam logic [1:0] CLS_WATER    = 2'd0;
    localparam logic [1:0] CLS_GRASS    = 2'd1;
    localparam logic [1:0] CLS_TREES    = 2'd2;
    localparam logic [1:0] CLS_MOUNTAIN = 2'd3;

    typedef logic [FRAC_BITS-1:0] t_frac;

    typedef struct packed {
        logic [31:0] seed;
        logic [15:0] water;
        logic [15:0] grass;
        logic [15:0] tree;
    } t_cfg;

    function automatic t_frac frac_of(input logic [15:0] f16);
        logic [39:0] w;
        begin
            w = {24'd0, f16};
            if (FRAC_BITS <= 16) begin
                w = w >> (16 - FRAC_BITS);
            end else begin
                w = w << (FRAC_BITS - 16);
            end
            frac_of = w[FRAC_BITS-1:0];
        end
    endfunction

    // Hash input mixing step.
    function automatic logic [31:0] hash_pre(input logic [31:0] x, input logic [31:0] ys);
        logic [31:0] n;
        begin
            n = x + ys;
            hash_pre = (n << 13) ^ n;
        end
    endfunction

endpackage

// ----- rtl/vntc_if.sv -----
// Valid/ready channel interface carrying one payload.
interface vntc_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/vntc_hash.sv -----
// Pipelined lattice hash of one point: three multiplier stages.
module vntc_hash (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_n,
    output logic [30:0] o_h
);
    import vntc_pkg::*;

    logic [31:0] r_n1, r_sq, r_n2, r_p, r_h;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n1 <= i_n;
            r_sq <= i_n * i_n;
            r_n2 <= r_n1;
            r_p  <= r_sq * 32'd15731 + 32'd789221;
            r_h  <= r_n2 * r_p + 32'd1376312589;
        end
    end

    assign o_h = r_h[30:0];
endmodule

// ----- rtl/value_noise_terrain_classifier.sv -----
// Top level of the value noise terrain classifier.
// Usage: the input channel carries one beat per tile with x_coord and y_coord;
// the output channel returns one beat with terrain_class (0 water, 1 grass,
// 2 trees, 3 mountains) for each input beat, in order.
// Registers are written over the APB port: seed, inv_scale and the water, grass
// and tree thresholds at byte addresses 0..16; the user must write them only
// while the block is idle; the block itself does not enforce it. The datapath
// is a pipeline of 12 stages: scaling, the y*seed product, mixing, three
// hash multiplier stages for the 16 lattice points, smoothing sums, two
// interpolation levels of two stages each and the classify compare.
// One beat is accepted every cycle while the output is taken, since every
// stage takes a new beat in each cycle that the pipeline advances.
// When the receiver stalls, the whole pipeline holds; the input is ready
// whenever the last stage is empty or is being taken.
// Reset is synchronous and active low: it empties the pipeline and loads the
// register defaults.
module value_noise_terrain_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vntc_if.sink        s_in,
    vntc_if.source      m_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vntc_pkg::*;

    localparam int NST = 12;

    logic [31:0] r_seed;
    logic [15:0] r_scale, r_water, r_grass, r_tree;
    logic [2:0]  w_idx;
    logic        w_wr, w_adv;
    logic [NST-1:0] r_vld;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= 32'd1;
            r_scale <= 16'd29789;
            r_water <= 16'd21299;
            r_grass <= 16'd36045;
            r_tree  <= 16'd42598;
        end else if (w_wr && paddr[1:0] == 2'd0) begin
            case (w_idx)
                REG_SEED:  r_seed  <= pwdata;
                REG_SCALE: r_scale <= pwdata[15:0];
                REG_WATER: r_water <= pwdata[15:0];
                REG_GRASS: r_grass <= pwdata[15:0];
                REG_TREE:  r_tree  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_SEED:  prdata = r_seed;
            REG_SCALE: prdata = {16'd0, r_scale};
            REG_WATER: prdata = {16'd0, r_water};
            REG_GRASS: prdata = {16'd0, r_grass};
            REG_TREE:  prdata = {16'd0, r_tree};
            default:   prdata = 32'd0;
        endcase
    end

    assign w_adv = !r_vld[NST-1] || m_out.ready;
    assign s_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], s_in.valid};
        end
    end

    // Stage 0: coordinate scaling.
    logic [47:0] r_px, r_py;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_px <= {16'd0, s_in.data.x_coord} * {32'd0, r_scale};
            r_py <= {16'd0, s_in.data.y_coord} * {32'd0, r_scale};
        end
    end

    // Stage 1: row products y*seed for the four lattice rows cy-1..cy+2.
    logic [31:0] w_cx, w_cy;
    assign w_cx = r_px[47:16];
    assign w_cy = r_py[47:16];
    logic [31:0] r_cx1, r_ys [4];
    t_frac r_tx [1:6], r_ty [1:8];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cx1 <= w_cx;
            for (int k = 0; k < 4; k++) begin
                r_ys[k] <= (w_cy + 32'(k) - 32'd1) * r_seed;
            end
            r_tx[1] <= frac_of(r_px[15:0]);
            r_ty[1] <= frac_of(r_py[15:0]);
            for (int s = 2; s <= 6; s++) begin
                r_tx[s] <= r_tx[s-1];
            end
            for (int s = 2; s <= 8; s++) begin
                r_ty[s] <= r_ty[s-1];
            end
        end
    end

    // Stage 2: mixing of the 4x4 lattice points; stages 3-5: hashes.
    logic [31:0] r_n [16];
    logic [30:0] w_h [16];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < 4; j++) begin
                for (int i = 0; i < 4; i++) begin
                    r_n[j*4+i] <= hash_pre(r_cx1 + 32'(i) - 32'd1, r_ys[j]);
                end
            end
        end
    end
    for (genvar g = 0; g < 16; g++) begin : g_hash
        vntc_hash u_hash (.i_clk(i_clk), .i_en(w_adv), .i_n(r_n[g]), .o_h(w_h[g]));
    end

    // Stage 6: smoothing of the four cell corners.
    function automatic logic [30:0] smooth(input logic [30:0] h [16], input int cx,
                                           input int cy);
        logic [35:0] acc;
        begin
            acc = 36'(h[(cy-1)*4+cx-1]) + 36'(h[(cy-1)*4+cx+1])
                + 36'(h[(cy+1)*4+cx-1]) + 36'(h[(cy+1)*4+cx+1])
                + ((36'(h[cy*4+cx-1]) + 36'(h[cy*4+cx+1])
                  + 36'(h[(cy-1)*4+cx]) + 36'(h[(cy+1)*4+cx])) << 1)
                + (36'(h[cy*4+cx]) << 2);
            smooth = acc[34:4];
        end
    endfunction
    logic [30:0] r_s00, r_s10, r_s01, r_s11;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s00 <= smooth(w_h, 1, 1);
            r_s10 <= smooth(w_h, 2, 1);
            r_s01 <= smooth(w_h, 1, 2);
            r_s11 <= smooth(w_h, 2, 2);
        end
    end

    // Stages 7-8: horizontal blends; stages 9-10: vertical blend.
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
    logic [LERP_W-1:0] r_ta, r_tb, r_ba, r_bb, r_va, r_vb;
    logic [30:0] r_top, r_bot;
    logic [LERP_W-1:0] w_top_sum, w_bot_sum, w_v_sum;
    assign w_top_sum = r_ta + r_tb;
    assign w_bot_sum = r_ba + r_bb;
    assign w_v_sum   = r_va + r_vb;
    logic [30:0] r_v;
    logic [1:0]  r_cls;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ta  <= LERP_W'(r_s00) * LERP_W'(ONE - {1'b0, r_tx[6]});
            r_tb  <= LERP_W'(r_s10) * LERP_W'(r_tx[6]);
            r_ba  <= LERP_W'(r_s01) * LERP_W'(ONE - {1'b0, r_tx[6]});
            r_bb  <= LERP_W'(r_s11) * LERP_W'(r_tx[6]);
            r_top <= w_top_sum[FRAC_BITS +: 31];
            r_bot <= w_bot_sum[FRAC_BITS +: 31];
            r_va  <= LERP_W'(r_top) * LERP_W'(ONE - {1'b0, r_ty[8]});
            r_vb  <= LERP_W'(r_bot) * LERP_W'(r_ty[8]);
            r_v   <= w_v_sum[FRAC_BITS +: 31];
            if (r_v < {r_water, 15'd0}) begin
                r_cls <= CLS_WATER;
            end else if (r_v < {r_grass, 15'd0}) begin
                r_cls <= CLS_GRASS;
            end else if (r_v < {r_tree, 15'd0}) begin
                r_cls <= CLS_TREES;
            end else begin
                r_cls <= CLS_MOUNTAIN;
            end
        end
    end

    assign m_out.valid = r_vld[NST-1];
    assign m_out.data.terrain_class = r_cls;

    logic w_unused;
    assign w_unused = ^{w_top_sum[LERP_W-1], w_top_sum[FRAC_BITS-1:0],
                        w_bot_sum[LERP_W-1], w_bot_sum[FRAC_BITS-1:0],
                        w_v_sum[LERP_W-1], w_v_sum[FRAC_BITS-1:0]};

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(r_cls))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_out.valid |-> s_in.ready)
        else $error("input blocked with empty output");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.ready && !r_vld[NST-1] |=> r_vld[0] == $past(s_in.valid))
        else $error("valid bit lost on entry");
endmodule
